### hdl/rcld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcld_pkg;

    // fixed result field widths
    localparam int CHAR_W      = 8;
    localparam int IDX_OUT_W   = 5;
    localparam int ERR_OUT_W   = 5;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;

    // configuration register widths and port shape
    localparam int MAX_ERR_W  = 3;
    localparam int LCOUNT_W   = 6;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 6;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ERRORS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_LETTER_COUNT = 1'b1;

    // reset values
    localparam logic [MAX_ERR_W-1:0] MAX_ERRORS_RST   = 3'd4;
    localparam logic [LCOUNT_W-1:0]  LETTER_COUNT_RST = 6'd26;

    // character codes
    localparam logic [CHAR_W-1:0] FIRST_LETTER = 8'd97;
    localparam logic [CHAR_W-1:0] REJECT_CODE  = 8'd63;

    typedef struct packed {
        logic [MAX_ERR_W-1:0] max_errors;
        logic [LCOUNT_W-1:0]  letter_count;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    char_code;
        logic                 valid_res;
        logic [IDX_OUT_W-1:0] letter_index;
        logic [ERR_OUT_W-1:0] error_count;
    } res_t;

endpackage

`default_nettype wire

### hdl/repetition_code_letter_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                  payload
// s_        in   s_tvalid / s_tready        s_tdata: received_word
// m_        out  m_tvalid / m_tready        m_tdata: char_code, letter_index,
//                                           error_count; m_tuser: valid_res
// cfg_      in   cfg_we (no back-pressure)  cfg_addr, cfg_data
//
// one word per cycle sustained while m_ is not stalled; a word passes through the
// input register, vote/sum/compare logic and result register
// reset clears both stage valids and loads the register reset values
// a stall on m_ holds the result; the input stage keeps accepting until
// both stages are full

module repetition_code_letter_decoder #(
    parameter int REPEAT     = 9,
    parameter int INDEX_BITS = 5,
    localparam int IN_TDATA_W = ((REPEAT * INDEX_BITS + 7) / 8) * 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [IN_TDATA_W-1:0]               s_tdata,  // received_word, zero pad
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rcld_pkg::OUT_TDATA_W-1:0]         m_tdata,  // char_code, letter_index,
                                                               // error_count, zero pad
    output logic [rcld_pkg::OUT_TUSER_W-1:0]         m_tuser,  // valid_res
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [rcld_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [rcld_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rcld_pkg::*;

    localparam int WORD_BITS = REPEAT * INDEX_BITS;
    localparam int PAD_W     = OUT_TDATA_W - CHAR_W - IDX_OUT_W - ERR_OUT_W;

    cfg_t                 cfg_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic                 in_vld_reg;
    logic                 in_vld_next;
    res_t                 res_reg;
    res_t                 res_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 out_adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_errors   <= MAX_ERRORS_RST;
            cfg_reg.letter_count <= LETTER_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAX_ERRORS:   cfg_reg.max_errors   <= cfg_data[MAX_ERR_W-1:0];
                REG_LETTER_COUNT: cfg_reg.letter_count <= cfg_data[LCOUNT_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // pipeline handshake
    assign out_adv      = !out_vld_reg || m_tready;
    assign s_tready     = !in_vld_reg || out_adv;
    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata[WORD_BITS-1:0];
        end
    end

    // decode logic
    rcld_decode #(
        .REPEAT     (REPEAT),
        .INDEX_BITS (INDEX_BITS)
    ) u_decode (
        .word (word_reg),
        .cfg  (cfg_reg),
        .res  (res_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_adv && in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {PAD_W'(0), res_reg.error_count, res_reg.letter_index,
                       res_reg.char_code};
    assign m_tuser  = OUT_TUSER_W'(res_reg.valid_res);

    // accepted result carries its letter
    a_letter_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.valid_res |->
            res_reg.char_code == FIRST_LETTER + CHAR_W'(res_reg.letter_index))
        else $error("accepted result has wrong letter code");

    // rejected result carries the reject code
    a_reject_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res_reg.valid_res |-> res_reg.char_code == REJECT_CODE)
        else $error("rejected result has wrong code");

    // accepted result stays within the error bound
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.valid_res |->
            res_reg.error_count <= ERR_OUT_W'(cfg_reg.max_errors))
        else $error("accepted result exceeds error bound");

    // a decoded word moving forward shows up as a result
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_adv |=> out_vld_reg)
        else $error("decoded word lost between stages");

endmodule

`default_nettype wire

### hdl/rcld_group_vote.sv
`timescale 1ns / 1ps
`default_nettype none

module rcld_group_vote #(
    parameter int REPEAT = 9,
    parameter int CNT_W  = $clog2(REPEAT + 1)
) (
    input  wire logic [REPEAT-1:0] bits,
    output logic                   bit_val,
    output logic [CNT_W-1:0]       flips
);

    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zeros;

    // population count of the group
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < REPEAT; i++)
        begin
            ones = ones + CNT_W'(bits[i]);
        end
    end

    // strict majority, a tie decodes to zero
    assign zeros   = CNT_W'(REPEAT) - ones;
    assign bit_val = ({1'b0, ones} << 1) > (CNT_W + 1)'(REPEAT);
    assign flips   = (ones < zeros) ? ones : zeros;

endmodule

`default_nettype wire

### hdl/rcld_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module rcld_decode #(
    parameter int REPEAT     = 9,
    parameter int INDEX_BITS = 5
) (
    input  wire logic [REPEAT*INDEX_BITS-1:0] word,
    input  wire rcld_pkg::cfg_t               cfg,
    output rcld_pkg::res_t                    res
);

    import rcld_pkg::*;

    localparam int CNT_W = $clog2(REPEAT + 1);
    localparam int ERR_W = $clog2(INDEX_BITS * (REPEAT / 2) + 1);
    localparam int CMP_W = (ERR_W > MAX_ERR_W) ? ERR_W : MAX_ERR_W;

    logic [INDEX_BITS-1:0] idx;
    logic [CNT_W-1:0]      flips [INDEX_BITS];
    logic [CMP_W-1:0]      err_sum;
    logic                  ok;

    // one majority voter per index bit
    for (genvar g = 0; g < INDEX_BITS; g++)
    begin : g_vote
        rcld_group_vote #(
            .REPEAT (REPEAT),
            .CNT_W  (CNT_W)
        ) u_vote (
            .bits    (word[g*REPEAT +: REPEAT]),
            .bit_val (idx[g]),
            .flips   (flips[g])
        );
    end

    // total distance to the nearest codeword
    always_comb
    begin
        err_sum = '0;
        for (int g = 0; g < INDEX_BITS; g++)
        begin
            err_sum = err_sum + CMP_W'(flips[g]);
        end
    end

    // acceptance and result word
    assign ok = (err_sum <= CMP_W'(cfg.max_errors))
             && (LCOUNT_W'(idx) < cfg.letter_count);

    always_comb
    begin
        res.char_code    = ok ? (FIRST_LETTER + CHAR_W'(idx)) : REJECT_CODE;
        res.valid_res    = ok;
        res.letter_index = IDX_OUT_W'(idx);
        res.error_count  = ERR_OUT_W'(err_sum);
    end

endmodule

`default_nettype wire

### bench/tb_repetition_code_letter_decoder.sv
`timescale 1ns / 1ps

module tb_repetition_code_letter_decoder;

    import rcld_pkg::*;

    localparam int REPEAT     = 9;
    localparam int INDEX_BITS = 5;
    localparam int WORD_W     = REPEAT * INDEX_BITS;
    localparam int IN_W       = ((WORD_W + 7) / 8) * 8;
    localparam int PHASES     = 10;
    localparam int PHASE_WORDS = 113;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;     // received_word, zero pad

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;    // char_code, letter_index, error_count, zero pad
    logic [OUT_TUSER_W-1:0] m_tuser;    // valid_res

    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // bench copy of the configuration registers
    logic [MAX_ERR_W-1:0] max_err_q = MAX_ERRORS_RST;
    logic [LCOUNT_W-1:0]  lcount_q  = LETTER_COUNT_RST;

    logic [WORD_W-1:0] pending_words[$];
    res_t              expected_letters[$];
    logic              word_done = 1'b0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                mismatch_count = 0;

    repetition_code_letter_decoder #(
        .REPEAT     (REPEAT),
        .INDEX_BITS (INDEX_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // majority vote per group, error sum and acceptance
    function automatic res_t decode_word(logic [WORD_W-1:0] w);
        res_t                  r;
        int                    ones;
        int                    errs;
        logic [INDEX_BITS-1:0] idx;
        logic                  ok;
        errs = 0;
        idx = '0;
        for (int g = 0; g < INDEX_BITS; g++)
        begin
            ones = 0;
            for (int b = 0; b < REPEAT; b++)
                ones += w[REPEAT * g + b];
            if (2 * ones > REPEAT)
                idx[g] = 1'b1;
            errs += (ones < REPEAT - ones) ? ones : REPEAT - ones;
        end
        ok = (errs <= int'(max_err_q)) && ({1'b0, idx} < lcount_q);
        r.char_code    = ok ? CHAR_W'(FIRST_LETTER + idx) : REJECT_CODE;
        r.valid_res    = ok;
        r.letter_index = idx;
        r.error_count  = errs[ERR_OUT_W-1:0];
        return r;
    endfunction

    // clean codeword for a letter index
    function automatic logic [WORD_W-1:0] codeword(logic [INDEX_BITS-1:0] idx);
        logic [WORD_W-1:0] w;
        for (int g = 0; g < INDEX_BITS; g++)
            for (int b = 0; b < REPEAT; b++)
                w[REPEAT * g + b] = idx[g];
        return w;
    endfunction

    // same pattern in every group
    function automatic logic [WORD_W-1:0] all_groups(logic [REPEAT-1:0] pat);
        logic [WORD_W-1:0] w;
        for (int g = 0; g < INDEX_BITS; g++)
            w[REPEAT * g +: REPEAT] = pat;
        return w;
    endfunction

    // mostly noisy codewords, half near the letter bound, some raw or heavily hit words
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0]     w;
        logic [INDEX_BITS-1:0] idx;
        int                    sel;
        int                    flips;
        sel = $urandom_range(99);
        if (sel < 80)
        begin
            if ($urandom_range(1) == 0 || lcount_q == 0)
                idx = INDEX_BITS'($urandom_range(31));
            else if (lcount_q > 32)
                idx = INDEX_BITS'(31 - $urandom_range(1));
            else
                idx = INDEX_BITS'(int'(lcount_q) - 1 + $urandom_range(1));
            w = codeword(idx);
            flips = $urandom_range(7);
        end
        else if (sel < 90)
        begin
            w = WORD_W'({$urandom, $urandom});
            flips = 0;
        end
        else
        begin
            w = codeword(INDEX_BITS'($urandom_range(31)));
            flips = $urandom_range(20, 8);
        end
        for (int k = 0; k < flips; k++)
            w[$urandom_range(WORD_W - 1)] ^= 1'b1;
        return w;
    endfunction

    task automatic report(string what, int got_v, int exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_MAX_ERRORS)
            max_err_q = data[MAX_ERR_W-1:0];
        else
            lcount_q = data[LCOUNT_W-1:0];
    endtask

    // hold until every queued word went in and every result came out
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_letters.size() != 0)
            @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_done))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(pending_words.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results, predict accepted words
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_letters.size() == 0)
                    report("unexpected word, char_code", m_tdata[7:0], 0);
                else
                begin
                    want = expected_letters.pop_front();
                    if (m_tdata[7:0] !== want.char_code)
                        report("char_code", m_tdata[7:0], want.char_code);
                    if (m_tuser[0] !== want.valid_res)
                        report("valid_res", m_tuser[0], want.valid_res);
                    if (m_tdata[12:8] !== want.letter_index)
                        report("letter_index", m_tdata[12:8], want.letter_index);
                    if (m_tdata[17:13] !== want.error_count)
                        report("error_count", m_tdata[17:13], want.error_count);
                end
            end
            if (s_tvalid && s_tready)
                expected_letters.push_back(decode_word(s_tdata[WORD_W-1:0]));
            word_done <= s_tvalid && s_tready;
        end
    end

    // stimulus
    initial
    begin
        logic [MAX_ERR_W-1:0] max_err_set[PHASES] = '{0, 4, 7, 2, 3, 1, 5, 6, 4, 0};
        logic [CFG_DATA_W-1:0] lcount_set[PHASES] = '{32, 1, 63, 0, 33, 26, 31, 2, 32, 1};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset settings
        send_idle_pct = 26;
        recv_idle_pct = 71;
        pending_words.push_back('0);
        pending_words.push_back('1);
        pending_words.push_back(codeword(INDEX_BITS'(1)));
        pending_words.push_back(codeword(INDEX_BITS'(16)));
        pending_words.push_back(codeword(INDEX_BITS'(25)));
        pending_words.push_back(codeword(INDEX_BITS'(26)));
        pending_words.push_back(codeword(INDEX_BITS'(31)));
        // four flips in one group: still corrected
        pending_words.push_back(codeword(INDEX_BITS'(0)) ^ WORD_W'(9'h00F));
        // five flips in one group: majority turns over
        pending_words.push_back(codeword(INDEX_BITS'(0)) ^ WORD_W'(9'h01F));
        // one flip per group: bound exceeded, decoded values still given
        pending_words.push_back(codeword(INDEX_BITS'(2)) ^ all_groups(9'h100));
        // worst case error count in both directions
        pending_words.push_back(all_groups(9'h00F));
        pending_words.push_back(all_groups(9'h1F0));
        pending_words.push_back(WORD_W'({(WORD_W / 2 + 1){2'b01}}));
        pending_words.push_back(WORD_W'({(WORD_W / 2 + 1){2'b10}}));
        pending_words.push_back(WORD_W'(1) << (WORD_W - 1));
        pending_words.push_back(WORD_W'(1));
        pending_words.push_back(~codeword(INDEX_BITS'(5)));
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_MAX_ERRORS, CFG_DATA_W'(max_err_set[p]));
            write_reg(REG_LETTER_COUNT, lcount_set[p]);
            if (p < 4)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 71;
            end
            else if (p < 7)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // first stretch without any idling
            begin
                int keep_send;
                int keep_recv;
                keep_send = send_idle_pct;
                keep_recv = recv_idle_pct;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                for (int i = 0; i < 20; i++)
                    pending_words.push_back(random_word());
                wait_drained();
                send_idle_pct = keep_send;
                recv_idle_pct = keep_recv;
            end
            for (int i = 20; i < PHASE_WORDS; i++)
                pending_words.push_back(random_word());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_letters.size() != 0)
            report("results left over", expected_letters.size(), 0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hdl/rcld_pkg.sv
hdl/rcld_group_vote.sv
hdl/rcld_decode.sv
hdl/repetition_code_letter_decoder.sv
bench/tb_repetition_code_letter_decoder.sv
